FILE: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 10;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int ITER_WIDTH      = 10;
  localparam int STEP_WIDTH      = 31;
  localparam int START_WIDTH     = 32;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_X_STEP  = 3'd2,
    REG_Y_STEP  = 3'd3,
    REG_MAX_IT  = 3'd4
  } reg_idx_e;

  localparam logic signed [START_WIDTH-1:0] START_X_RESET  = 32'shE000_0000;
  localparam logic signed [START_WIDTH-1:0] START_Y_RESET  = 32'sd201326592;
  localparam logic [STEP_WIDTH-1:0]         X_STEP_RESET   = 31'd10066329;
  localparam logic [STEP_WIDTH-1:0]         Y_STEP_RESET   = 31'd16710107;
  localparam logic [ITER_WIDTH-1:0]         MAX_IT_RESET   = 10'd40;

  localparam int GLYPH_CYCLE = 5;
  localparam int COLOR_CYCLE = 6;
  localparam int COLOR_BASE  = 2;

  localparam logic [7:0] GLYPH_DOT    = 8'h2E;
  localparam logic [7:0] GLYPH_COMMA  = 8'h2C;
  localparam logic [7:0] GLYPH_STAR   = 8'h2A;
  localparam logic [7:0] GLYPH_DOLLAR = 8'h24;
  localparam logic [7:0] GLYPH_AT     = 8'h40;
  localparam logic [7:0] GLYPH_HASH   = 8'h23;
  localparam logic [7:0] GLYPH_PCT    = 8'h25;

  typedef struct packed {
    logic signed [START_WIDTH-1:0] start_x;
    logic signed [START_WIDTH-1:0] start_y;
    logic [STEP_WIDTH-1:0]         x_step;
    logic [STEP_WIDTH-1:0]         y_step;
    logic [ITER_WIDTH-1:0]         max_it;
  } cfg_t;

endpackage

FILE: hw/rtl/mbe_intf.sv
interface mbe_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] column;
  logic [9:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink (input valid, input column, input row, output ready);
endinterface

interface mbe_out_if;
  logic                          valid;
  logic                          ready;
  logic [mbe_pkg::ITER_WIDTH-1:0] iterations;
  logic                          inside_res;
  logic [7:0]                    glyph;
  logic [2:0]                    palette;

  modport source (output valid, output iterations, output inside_res, output glyph,
                  output palette, input ready);
  modport sink (input valid, input iterations, input inside_res, input glyph,
                input palette, output ready);
endinterface

interface mbe_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mandelbrot_escape_time_pixel_top.sv
// one cell at a time; a new cell is taken only once the last result is in the output register
// each iteration runs on the one shared coordinate multiplier, which also maps the cell to c
// (x*x, y*y, x*y, then compare and update); the result then moves to the output register,
// and a stalled result holds off the next cell
// reset: asynchronous active-low; control and output registers return to their defaults, no result pending
module mandelbrot_escape_time_pixel_top #(
  parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS,
  parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbe_in_if.sink    in_i,
  mbe_out_if.source out_o,
  mbe_cfg_if.sink   cfg_i
);

  mbe_pkg::cfg_t regs;

  mbe_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  mbe_core #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (regs),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

FILE: hw/rtl/mbe_cfg.sv
module mbe_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  mbe_cfg_if.sink         cfg_i,
  output mbe_pkg::cfg_t   regs_o
);

  mbe_pkg::cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.start_x <= mbe_pkg::START_X_RESET;
      regs_q.start_y <= mbe_pkg::START_Y_RESET;
      regs_q.x_step  <= mbe_pkg::X_STEP_RESET;
      regs_q.y_step  <= mbe_pkg::Y_STEP_RESET;
      regs_q.max_it  <= mbe_pkg::MAX_IT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mbe_pkg::REG_START_X: regs_q.start_x <= cfg_i.data[mbe_pkg::START_WIDTH-1:0];
        mbe_pkg::REG_START_Y: regs_q.start_y <= cfg_i.data[mbe_pkg::START_WIDTH-1:0];
        mbe_pkg::REG_X_STEP:  regs_q.x_step  <= cfg_i.data[mbe_pkg::STEP_WIDTH-1:0];
        mbe_pkg::REG_Y_STEP:  regs_q.y_step  <= cfg_i.data[mbe_pkg::STEP_WIDTH-1:0];
        mbe_pkg::REG_MAX_IT:  regs_q.max_it  <= cfg_i.data[mbe_pkg::ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/mbe_mul.sv
module mbe_mul #(
  parameter int OPW = mbe_pkg::COORD_WIDTH + 1
) (
  input  logic                    clk_i,
  input  logic signed [OPW-1:0]   a_i,
  input  logic signed [OPW-1:0]   b_i,
  output logic signed [2*OPW-1:0] p_o
);

  logic signed [2*OPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*OPW)'(a_i) * (2*OPW)'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/mbe_core.sv
module mbe_core #(
  parameter int COORD_WIDTH = mbe_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = mbe_pkg::FRAC_BITS,
  parameter int COUNT_WIDTH = mbe_pkg::COUNT_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbe_pkg::cfg_t  cfg_i,
  mbe_in_if.sink         in_i,
  mbe_out_if.source      out_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NW  = COUNT_WIDTH;
  localparam int OPW = CW + 1;
  localparam int PW  = 2 * OPW;
  localparam int EW  = PW + F;
  localparam int THW = (PW + 1 > 2 * F + 3) ? PW + 1 : 2 * F + 3;
  localparam int SXW = (CW > mbe_pkg::START_WIDTH) ? CW : mbe_pkg::START_WIDTH;
  localparam int STW = (CW > mbe_pkg::STEP_WIDTH) ? CW : mbe_pkg::STEP_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_MAPC,
    S_MULX,
    S_MULY,
    S_MULXY,
    S_STEP
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  logic [9:0]      col_q, col_d, row_q, row_d;
  logic [CW-1:0]   cx_q, cx_d, cy_q, cy_d, x_q, x_d, y_q, y_d;
  logic [PW-1:0]   xx_q, xx_d;
  logic signed [PW-1:0] diff_q, diff_d;
  logic            esc_q, esc_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic [2:0]      mod_q, mod_d, div_q, div_d;

  logic                            out_valid_q, out_valid_d;
  logic [mbe_pkg::ITER_WIDTH-1:0]  iter_q, iter_d;
  logic                            inside_q, inside_d;
  logic [7:0]                      glyph_q, glyph_d;
  logic [2:0]                      color_q, color_d;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PW-1:0]  prod;
  logic [PW-1:0]         prod_u;
  logic signed [SXW-1:0] sx_ext, sy_ext;
  logic [STW-1:0]        xs_ext, ys_ext;
  logic signed [EW-1:0]  diff_ext, xy_ext;
  logic [THW-1:0]        sq_sum, thr;
  logic [NW-1:0]         max_n;
  logic                  at_limit;
  logic [7:0]            sym;

  mbe_mul #(.OPW(OPW)) u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign prod_u   = $unsigned(prod);
  assign sx_ext   = SXW'(cfg_i.start_x);
  assign sy_ext   = SXW'(cfg_i.start_y);
  assign xs_ext   = STW'(cfg_i.x_step);
  assign ys_ext   = STW'(cfg_i.y_step);
  assign diff_ext = EW'(diff_q);
  assign xy_ext   = EW'(prod);
  assign sq_sum   = THW'(xx_q) + THW'(prod_u);
  assign thr      = THW'(1) << (2 * F + 2);
  assign max_n    = NW'(cfg_i.max_it);
  assign at_limit = (cnt_q >= max_n);

  always_comb begin
    case (mod_q)
      3'd0:    sym = mbe_pkg::GLYPH_STAR;
      3'd1:    sym = mbe_pkg::GLYPH_DOLLAR;
      3'd2:    sym = mbe_pkg::GLYPH_AT;
      3'd3:    sym = mbe_pkg::GLYPH_HASH;
      default: sym = mbe_pkg::GLYPH_PCT;
    endcase
  end

  assign in_i.ready       = (state_q == S_IDLE) && !fin_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.iterations = iter_q;
  assign out_o.inside_res = inside_q;
  assign out_o.glyph      = glyph_q;
  assign out_o.palette    = color_q;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    col_d       = col_q;
    row_d       = row_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    x_d         = x_q;
    y_d         = y_q;
    xx_d        = xx_q;
    diff_d      = diff_q;
    esc_d       = esc_q;
    cnt_d       = cnt_q;
    mod_d       = mod_q;
    div_d       = div_q;
    out_valid_d = out_valid_q && !out_o.ready;
    iter_d      = iter_q;
    inside_d    = inside_q;
    glyph_d     = glyph_q;
    color_d     = color_q;
    op_a        = {x_q[CW-1], x_q};
    op_b        = {x_q[CW-1], x_q};

    // result waits for a free output register
    if (fin_q && (!out_valid_q || out_o.ready)) begin
      fin_d       = 1'b0;
      out_valid_d = 1'b1;
      iter_d      = mbe_pkg::ITER_WIDTH'(cnt_q);
      inside_d    = at_limit;
      if (at_limit) begin
        glyph_d = 8'd0;
        color_d = 3'd0;
      end else begin
        if (cnt_q < NW'(3)) begin
          glyph_d = mbe_pkg::GLYPH_DOT;
        end else if (cnt_q == NW'(3)) begin
          glyph_d = mbe_pkg::GLYPH_COMMA;
        end else begin
          glyph_d = sym;
        end
        color_d = div_q + 3'(mbe_pkg::COLOR_BASE);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && !fin_q) begin
          col_d   = in_i.column;
          row_d   = in_i.row;
          state_d = S_MAPX;
        end
      end
      S_MAPX: begin
        op_a    = {1'b0, CW'(col_q)};
        op_b    = {1'b0, xs_ext[CW-1:0]};
        state_d = S_MAPY;
      end
      S_MAPY: begin
        op_a    = {1'b0, CW'(row_q)};
        op_b    = {1'b0, ys_ext[CW-1:0]};
        cx_d    = sx_ext[CW-1:0] + prod_u[CW-1:0];
        x_d     = sx_ext[CW-1:0] + prod_u[CW-1:0];
        state_d = S_MAPC;
      end
      S_MAPC: begin
        cy_d    = sy_ext[CW-1:0] - prod_u[CW-1:0];
        y_d     = sy_ext[CW-1:0] - prod_u[CW-1:0];
        cnt_d   = '0;
        mod_d   = 3'd0;
        div_d   = 3'd0;
        state_d = S_MULY;
      end
      S_MULX: begin
        state_d = S_MULY;
      end
      S_MULY: begin
        op_a    = {y_q[CW-1], y_q};
        op_b    = {y_q[CW-1], y_q};
        xx_d    = prod_u;
        state_d = S_MULXY;
      end
      S_MULXY: begin
        op_a    = {x_q[CW-1], x_q};
        op_b    = {y_q[CW-1], y_q};
        diff_d  = $signed(xx_q - prod_u);
        esc_d   = (sq_sum > thr);
        state_d = S_STEP;
      end
      S_STEP: begin
        if (esc_q || at_limit) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          x_d   = diff_ext[F+CW-1:F] + cx_q;
          y_d   = xy_ext[F+CW-2:F-1] + cy_q;
          cnt_d = cnt_q + NW'(1);
          if (mod_q == 3'(mbe_pkg::GLYPH_CYCLE - 1)) begin
            mod_d = 3'd0;
            div_d = (div_q == 3'(mbe_pkg::COLOR_CYCLE - 1)) ? 3'd0 : div_q + 3'd1;
          end else begin
            mod_d = mod_q + 3'd1;
          end
          state_d = S_MULX;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      inside_q    <= 1'b0;
      glyph_q     <= 8'd0;
      color_q     <= 3'd0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      iter_q      <= iter_d;
      inside_q    <= inside_d;
      glyph_q     <= glyph_d;
      color_q     <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    x_q    <= x_d;
    y_q    <= y_d;
    xx_q   <= xx_d;
    diff_q <= diff_d;
    esc_q  <= esc_d;
    cnt_q  <= cnt_d;
    mod_q  <= mod_d;
    div_q  <= div_d;
  end

endmodule
